FILE: design/mmps_pkg.sv
// ----------------------------------------------------------------------------
// mmps_pkg
// Shared types, codes and default sizes of the wildcard signature scanner.
// ----------------------------------------------------------------------------
package mmps_pkg;

  localparam int unsigned DefPatterns = 16;
  localparam int unsigned DefMaxLen   = 32;
  localparam int unsigned AddrW       = 48;
  localparam int unsigned MaxRes      = 16;

  // input modes
  localparam logic [2:0] ModeLoad     = 3'd0;
  localparam logic [2:0] ModeScan     = 3'd1;
  localparam logic [2:0] ModeRead     = 3'd2;
  localparam logic [2:0] ModeClrRes   = 3'd3;
  localparam logic [2:0] ModeClrSig   = 3'd4;

  // result kinds
  localparam logic [1:0] KindMatch    = 2'd0;
  localparam logic [1:0] KindRead     = 2'd1;
  localparam logic [1:0] KindReject   = 2'd2;

  // command from the top level to every slot cell
  typedef struct packed {
    logic load;        // load a position into the addressed cell
    logic load_last;   // final position of the load
    logic load_reject; // position beyond the maximum length
    logic clr_res;     // drop recorded matches
    logic clr_sig;     // drop signatures and matches
    logic scan;        // scan byte shifted in this cycle
    logic [5:0] pos;
    logic [7:0] data;
    logic wild;
  } mmps_cmd_t;

endpackage

FILE: design/mmps_slot_cell.sv
// ----------------------------------------------------------------------------
// mmps_slot_cell
// One signature slot: pattern storage, length, valid and match record.
// The window bus taps into the cell and passes on to the next cell.
// ----------------------------------------------------------------------------
module mmps_slot_cell #(
  parameter int unsigned MaxLen = mmps_pkg::DefMaxLen,
  parameter int unsigned AddrW  = mmps_pkg::AddrW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmps_pkg::mmps_cmd_t cmd_i,
  input  logic                sel_i,
  input  logic [6:0]          fill_i,
  input  logic [MaxLen*8-1:0] win_i,
  input  logic                rec_i,
  input  logic [AddrW-1:0]    rec_addr_i,
  output logic [MaxLen*8-1:0] win_o,
  output logic                hit_o,
  output logic                valid_o,
  output logic                seen_o,
  output logic [AddrW-1:0]    start_o,
  output logic [6:0]          len_o
);

  localparam int unsigned IW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  logic [7:0]  sig_q [MaxLen];
  logic [MaxLen-1:0] wild_q;
  logic [6:0]  len_q;
  logic        valid_q;
  logic        seen_q;
  logic [AddrW-1:0] start_q;
  logic [MaxLen-1:0] pos_ok;

  // signature storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && sel_i && !cmd_i.load_reject) begin
      sig_q[cmd_i.pos[IW-1:0]]  <= cmd_i.data;
      wild_q[cmd_i.pos[IW-1:0]] <= cmd_i.wild;
    end
  end

  // current window handed on to the next cell
  assign win_o = win_i;

  // control state of the slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      valid_q <= 1'b0;
      seen_q  <= 1'b0;
      start_q <= '0;
    end else begin
      if (cmd_i.clr_sig) begin
        len_q <= '0; valid_q <= 1'b0; seen_q <= 1'b0; start_q <= '0;
      end else if (cmd_i.clr_res) begin
        seen_q <= 1'b0; start_q <= '0;
      end else if (cmd_i.load && sel_i) begin
        valid_q <= 1'b0; seen_q <= 1'b0; start_q <= '0;
        if (cmd_i.load_reject) len_q <= '0;
        else if (cmd_i.load_last) begin
          len_q   <= 7'(cmd_i.pos) + 7'd1;
          valid_q <= 1'b1;
        end
      end else if (rec_i) begin
        seen_q  <= 1'b1;
        start_q <= rec_addr_i;
      end
    end
  end

  // per-position compare against the window; index 0 newest
  always_comb begin
    for (int i = 0; i < MaxLen; i++) begin
      if (i >= len_q) pos_ok[i] = 1'b1;
      else pos_ok[i] = wild_q[i] ||
        (win_i[(int'(len_q) - 1 - i) * 8 +: 8] == sig_q[i]);
    end
  end

  assign hit_o = valid_q && !seen_q && len_q != '0 && len_q <= fill_i && (&pos_ok);
  assign valid_o = valid_q;
  assign seen_o  = seen_q;
  assign start_o = start_q;
  assign len_o   = len_q;

endmodule

FILE: design/masked_multi_pattern_scan_core.sv
// ----------------------------------------------------------------------------
// masked_multi_pattern_scan_core
// Wildcard byte signature scanner built from a row of slot cells.
// ----------------------------------------------------------------------------
// Timing: a read or reject result is registered at the accepting edge; the
// first match of a scan is registered from the pending set of its hits.
// Throughput: one item per cycle for loads, reads and clears unless output
// stalls; a scan with matches holds input as they drain in slot order.
// Reset: asynchronous active low; lengths, valid bits, matches and window
// clear at once, signature bytes are undefined until loaded.
module masked_multi_pattern_scan_core #(
  parameter int unsigned PATTERNS = mmps_pkg::DefPatterns,
  parameter int unsigned MAX_LEN  = mmps_pkg::DefMaxLen
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  pattern_index_i,
  input  logic [4:0]  byte_pos_i,
  input  logic [7:0]  data_byte_i,
  input  logic        wildcard_req_i,
  input  logic        last_of_pattern_i,
  input  logic [47:0] address_i,
  input  logic        region_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [47:0] match_address_o,
  output logic        found_o,
  output logic        all_found_o,
  output logic        last_o
);
  localparam int unsigned AW = mmps_pkg::AddrW;
  localparam int unsigned SW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;

  logic [MAX_LEN*8-1:0] win_q, win_d;
  logic [6:0] fill_q, fill_d;
  logic [PATTERNS-1:0] pend_q, hit, valid_v, seen_v, rec;
  logic [AW-1:0] addr_q;
  logic [4:0] nres_q;
  logic busy_q;
  logic [MAX_LEN*8-1:0] chain [PATTERNS+1];
  logic [AW-1:0] start_v [PATTERNS];
  logic [6:0] len_v [PATTERNS];
  mmps_pkg::mmps_cmd_t cmd;
  logic acc, out_fire, all_done;
  logic [SW-1:0] pick;
  logic pick_any;
  logic [PATTERNS-1:0] pend_rest;

  assign acc = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o = !busy_q && (!out_valid_o || out_ready_i);

  // window after this scan byte
  always_comb begin
    win_d  = {win_q[MAX_LEN*8-9:0], data_byte_i};
    fill_d = region_start_i ? 7'd0 : fill_q;
    if (fill_d < 7'(MAX_LEN)) fill_d = fill_d + 7'd1;
  end

  // command broadcast
  always_comb begin
    cmd = '0;
    cmd.load        = acc && mode_i == mmps_pkg::ModeLoad;
    cmd.load_last   = last_of_pattern_i;
    cmd.load_reject = 7'(byte_pos_i) >= 7'(MAX_LEN);
    cmd.clr_res     = acc && mode_i == mmps_pkg::ModeClrRes;
    cmd.clr_sig     = acc && mode_i == mmps_pkg::ModeClrSig;
    cmd.scan        = acc && mode_i == mmps_pkg::ModeScan;
    cmd.pos         = 6'(byte_pos_i);
    cmd.data        = data_byte_i;
    cmd.wild        = wildcard_req_i;
  end

  assign chain[0] = win_d;
  for (genvar s = 0; s < PATTERNS; s++) begin : g_cell
    mmps_slot_cell #(.MaxLen(MAX_LEN), .AddrW(AW)) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd),
      .sel_i(32'(pattern_index_i) == s),
      .fill_i(fill_d), .win_i(chain[s]),
      .rec_i(rec[s]), .rec_addr_i(addr_q - AW'(len_v[s] - 7'd1)),
      .win_o(chain[s+1]), .hit_o(hit[s]), .valid_o(valid_v[s]),
      .seen_o(seen_v[s]), .start_o(start_v[s]), .len_o(len_v[s])
    );
  end

  assign all_done = (|valid_v) && ((valid_v & ~seen_v) == '0);

  // lowest pending slot
  always_comb begin
    pick = '0; pick_any = 1'b0;
    for (int s = PATTERNS-1; s >= 0; s--)
      if (pend_q[s]) begin pick = SW'(s); pick_any = 1'b1; end
    pend_rest = pend_q;
    pend_rest[pick] = 1'b0;
  end

  // record the match being emitted
  always_comb begin
    rec = '0;
    if (busy_q && pick_any && (!out_valid_o || out_ready_i)) rec[pick] = 1'b1;
  end

  // window, scan capture and drain control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0; fill_q <= '0; pend_q <= '0; busy_q <= 1'b0;
      nres_q <= '0; addr_q <= '0;
    end else begin
      if (cmd.scan) begin
        win_q <= win_d; fill_q <= fill_d;
        addr_q <= address_i; nres_q <= '0;
        if (!all_done && (|hit)) begin
          pend_q <= hit; busy_q <= 1'b1;
        end
      end else if (|rec) begin
        nres_q <= nres_q + 5'd1;
        if (pend_rest == '0 || nres_q == 5'(mmps_pkg::MaxRes - 1)) begin
          pend_q <= '0; busy_q <= 1'b0;
        end else pend_q <= pend_rest;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (|rec) out_valid_o <= 1'b1;
    else if (acc && (mode_i == mmps_pkg::ModeRead ||
             (cmd.load && 32'(pattern_index_i) < PATTERNS && cmd.load_reject)))
      out_valid_o <= 1'b1;
    else if (out_fire) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (|rec) begin
      kind_o <= mmps_pkg::KindMatch; slot_o <= 4'(pick);
      match_address_o <= addr_q - AW'(len_v[pick] - 7'd1);
      found_o <= 1'b1;
      all_found_o <= ((valid_v & ~(seen_v | rec)) == '0);
      last_o <= (pend_rest == '0) || nres_q == 5'(mmps_pkg::MaxRes - 1);
    end else if (acc && mode_i == mmps_pkg::ModeRead) begin
      kind_o <= mmps_pkg::KindRead; slot_o <= pattern_index_i;
      last_o <= 1'b1; all_found_o <= all_done;
      if (32'(pattern_index_i) < PATTERNS && seen_v[SW'(pattern_index_i)]) begin
        found_o <= 1'b1; match_address_o <= start_v[SW'(pattern_index_i)];
      end else begin
        found_o <= 1'b0; match_address_o <= '0;
      end
    end else if (acc && cmd.load) begin
      kind_o <= mmps_pkg::KindReject; slot_o <= pattern_index_i;
      match_address_o <= '0; found_o <= 1'b0; last_o <= 1'b1;
      all_found_o <= (|(valid_v & ~(PATTERNS'(1) << SW'(pattern_index_i)))) &&
        ((valid_v & ~seen_v & ~(PATTERNS'(1) << SW'(pattern_index_i))) == '0);
    end
  end

`ifndef ASSERT_OFF
  a_busy_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pend_q != '0) else $error("busy with nothing pending");
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o) else $error("accept while draining");
  a_rec_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(rec)) else $error("more than one record");
`endif

endmodule

FILE: sim/masked_multi_pattern_scan_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_multi_pattern_scan_core_tb
// Self-checking bench for the wildcard signature scanner. Signature loads,
// scans, reads and clears go through a bursty driver. A scoreboard model
// predicts every result, and a stalling monitor compares each one in order.
// ----------------------------------------------------------------------------
module masked_multi_pattern_scan_core_tb;

  localparam int unsigned NumSlots   = mmps_pkg::DefPatterns;
  localparam int unsigned SigLen     = mmps_pkg::DefMaxLen;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldStart  = 300;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ItemTarget = 380;
  localparam logic [2:0]  ModeSpareLo = 3'd5;
  localparam logic [2:0]  ModeSpareHi = 3'd7;
  localparam logic [47:0] AddrMask   = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  idx;
    logic [4:0]  pos;
    logic [7:0]  data;
    logic        wild;
    logic        lastp;
    logic [47:0] addr;
    logic        rstart;
  } scan_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [47:0] addr;
    logic        found;
    logic        all_found;
    logic        last;
  } scan_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode = '0;
  logic [3:0]  pattern_index = '0;
  logic [4:0]  byte_pos = '0;
  logic [7:0]  data_byte = '0;
  logic        wildcard_req = 1'b0;
  logic        last_of_pattern = 1'b0;
  logic [47:0] address = '0;
  logic        region_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [47:0] match_address;
  logic        found;
  logic        all_found;
  logic        last;

  masked_multi_pattern_scan_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .mode_i            (mode),
    .pattern_index_i   (pattern_index),
    .byte_pos_i        (byte_pos),
    .data_byte_i       (data_byte),
    .wildcard_req_i    (wildcard_req),
    .last_of_pattern_i (last_of_pattern),
    .address_i         (address),
    .region_start_i    (region_start),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .kind_o            (kind),
    .slot_o            (slot),
    .match_address_o   (match_address),
    .found_o           (found),
    .all_found_o       (all_found),
    .last_o            (last)
  );

  // scoreboard model state
  logic [7:0]  sig_byte  [NumSlots][SigLen];
  logic        sig_wild  [NumSlots][SigLen];
  logic [5:0]  sig_len   [NumSlots];
  logic        sig_valid [NumSlots];
  logic [47:0] hit_addr  [NumSlots];
  logic        hit_seen  [NumSlots];
  logic [7:0]  win       [SigLen];
  int unsigned win_fill;
  logic [SigLen-1:0] loaded_pos [NumSlots];

  scan_item_t   pending_q[$];
  scan_result_t expected_q[$];
  int unsigned  n_errors, n_results, n_matches, n_items, cycles;
  logic [47:0]  scan_addr;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    n_errors++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  function automatic logic every_found();
    logic any;
    any = 1'b0;
    for (int s = 0; s < NumSlots; s++) begin
      if (sig_valid[s]) begin
        any = 1'b1;
        if (!hit_seen[s]) return 1'b0;
      end
    end
    return any;
  endfunction

  function automatic logic slot_hits(input int s);
    int unsigned len;
    len = sig_len[s];
    if (!sig_valid[s] || hit_seen[s] || len == 0 || len > SigLen || len > win_fill)
      return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (!sig_wild[s][i] && win[len-1-i] != sig_byte[s][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // update the model with one item and queue the results it causes
  task automatic predict_results(input scan_item_t it);
    scan_result_t r;
    logic done_before;
    int n;
    n = 0;
    case (it.mode)
      mmps_pkg::ModeLoad: begin
        sig_valid[it.idx] = 1'b0;
        hit_seen[it.idx]  = 1'b0;
        hit_addr[it.idx]  = '0;
        if (it.pos >= SigLen) begin
          sig_len[it.idx] = '0;
          r = '{mmps_pkg::KindReject, it.idx, 48'd0, 1'b0, every_found(), 1'b1};
          expected_q.push_back(r);
        end else begin
          sig_byte[it.idx][it.pos] = it.data;
          sig_wild[it.idx][it.pos] = it.wild;
          if (it.lastp) begin
            sig_len[it.idx]   = 6'(it.pos) + 6'd1;
            sig_valid[it.idx] = 1'b1;
          end
        end
      end
      mmps_pkg::ModeScan: begin
        done_before = every_found();
        if (it.rstart) win_fill = 0;
        for (int i = SigLen - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = it.data;
        if (win_fill < SigLen) win_fill++;
        if (!done_before) begin
          for (int s = 0; s < NumSlots && n < mmps_pkg::MaxRes; s++) begin
            if (slot_hits(s)) begin
              hit_seen[s] = 1'b1;
              hit_addr[s] = (it.addr - 48'(sig_len[s] - 1)) & AddrMask;
              r = '{mmps_pkg::KindMatch, 4'(s), hit_addr[s], 1'b1, every_found(), 1'b0};
              expected_q.push_back(r);
              n++;
            end
          end
          if (n > 0) expected_q[expected_q.size()-1].last = 1'b1;
        end
      end
      mmps_pkg::ModeRead: begin
        if (hit_seen[it.idx])
          r = '{mmps_pkg::KindRead, it.idx, hit_addr[it.idx], 1'b1, every_found(), 1'b1};
        else
          r = '{mmps_pkg::KindRead, it.idx, 48'd0, 1'b0, every_found(), 1'b1};
        expected_q.push_back(r);
      end
      mmps_pkg::ModeClrRes: begin
        for (int s = 0; s < NumSlots; s++) begin
          hit_seen[s] = 1'b0;
          hit_addr[s] = '0;
        end
      end
      mmps_pkg::ModeClrSig: begin
        for (int s = 0; s < NumSlots; s++) begin
          sig_valid[s] = 1'b0;
          sig_len[s]   = '0;
          hit_seen[s]  = 1'b0;
          hit_addr[s]  = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [2:0] m, input logic [3:0] idx,
                          input logic [4:0] pos, input logic [7:0] data,
                          input logic wild, input logic lastp,
                          input logic [47:0] addr, input logic rstart);
    scan_item_t it;
    // never validate a slot with positions unwritten since reset
    if (m == mmps_pkg::ModeLoad) begin
      loaded_pos[idx][pos] = 1'b1;
      for (int p = 0; p <= pos; p++) if (!loaded_pos[idx][p]) lastp = 1'b0;
    end
    it = '{m, idx, pos, data, wild, lastp, addr, rstart};
    pending_q.push_back(it);
    predict_results(it);
    n_items++;
  endtask

  task automatic load_signature(input int s, input int len, input int wild_pct);
    for (int p = 0; p < len; p++)
      add_item(mmps_pkg::ModeLoad, 4'(s), 5'(p), 8'($urandom),
               ($urandom_range(0, 99) < wild_pct), (p == len - 1),
               {16'($urandom), $urandom}, 1'($urandom));
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic rstart);
    if (rstart) scan_addr = {16'($urandom), $urandom};
    else scan_addr = scan_addr + 48'd1;
    add_item(mmps_pkg::ModeScan, 4'($urandom), 5'($urandom), b, 1'($urandom),
             1'($urandom), scan_addr, rstart);
  endtask

  // stimulus and end of run
  initial begin
    int s, len;
    win_fill = 0;
    for (int i = 0; i < SigLen; i++) win[i] = '0;
    for (int k = 0; k < NumSlots; k++) begin
      sig_len[k] = '0; sig_valid[k] = 1'b0; hit_addr[k] = '0; hit_seen[k] = 1'b0;
      loaded_pos[k] = '0;
      for (int i = 0; i < SigLen; i++) begin
        sig_byte[k][i] = '0; sig_wild[k][i] = 1'b0;
      end
    end
    scan_addr = '0;

    // directed: scans with nothing valid, extremes, wrap, wildcards
    add_item(mmps_pkg::ModeScan, 4'd0, 5'd0, 8'hFF, 1'b0, 1'b0, 48'd0, 1'b1);
    add_item(mmps_pkg::ModeRead, 4'd7, 5'd0, 8'h00, 1'b0, 1'b0, 48'd0, 1'b0);
    add_item(mmps_pkg::ModeLoad, 4'd0, 5'd0, 8'hFF, 1'b0, 1'b1, AddrMask, 1'b1);
    add_item(mmps_pkg::ModeLoad, 4'd15, 5'd0, 8'h00, 1'b1, 1'b0, 48'd0, 1'b0);
    add_item(mmps_pkg::ModeLoad, 4'd15, 5'd1, 8'hAA, 1'b0, 1'b1, 48'd0, 1'b0);
    add_item(mmps_pkg::ModeScan, 4'd0, 5'd0, 8'h55, 1'b0, 1'b0, AddrMask, 1'b1);
    add_item(mmps_pkg::ModeScan, 4'd0, 5'd0, 8'hAA, 1'b0, 1'b0, 48'd0, 1'b0);
    add_item(mmps_pkg::ModeScan, 4'd0, 5'd0, 8'hFF, 1'b0, 1'b0, 48'd1, 1'b0);
    add_item(mmps_pkg::ModeScan, 4'd0, 5'd0, 8'hFF, 1'b0, 1'b0, 48'd2, 1'b0);
    add_item(mmps_pkg::ModeRead, 4'd15, 5'd0, 8'h00, 1'b0, 1'b0, 48'd0, 1'b0);
    add_item(mmps_pkg::ModeRead, 4'd0, 5'd0, 8'h00, 1'b0, 1'b0, 48'd0, 1'b0);
    add_item(ModeSpareLo, 4'd0, 5'd0, 8'h00, 1'b0, 1'b0, 48'd0, 1'b0);
    add_item(ModeSpareHi, 4'd15, 5'd31, 8'hFF, 1'b1, 1'b1, AddrMask, 1'b1);
    add_item(mmps_pkg::ModeClrRes, 4'd0, 5'd0, 8'h00, 1'b0, 1'b0, 48'd0, 1'b0);
    add_item(mmps_pkg::ModeRead, 4'd0, 5'd0, 8'h00, 1'b0, 1'b0, 48'd0, 1'b0);
    // full-length all-wildcard signature, then a signature clear drops it
    load_signature(3, SigLen, 100);
    add_item(mmps_pkg::ModeClrSig, 4'd0, 5'd0, 8'h00, 1'b0, 1'b0, 48'd0, 1'b0);

    // random: well-formed load/scan phases plus noise
    while (n_items < ItemTarget) begin
      if ($urandom_range(0, 3) == 0)
        add_item(mmps_pkg::ModeClrSig, 4'($urandom), 5'($urandom), 8'($urandom),
                 1'($urandom), 1'($urandom), {16'($urandom), $urandom}, 1'($urandom));
      repeat ($urandom_range(1, 5)) begin
        s = $urandom_range(0, NumSlots - 1);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, SigLen)
                                           : $urandom_range(1, 4);
        load_signature(s, len, 20);
      end
      repeat ($urandom_range(20, 50)) begin
        case ($urandom_range(0, 15))
          0: add_item(mmps_pkg::ModeRead, 4'($urandom), 5'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom), {16'($urandom), $urandom},
                      1'($urandom));
          1: add_item(3'($urandom_range(mmps_pkg::ModeClrRes, ModeSpareHi)),
                      4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom),
                      1'($urandom), {16'($urandom), $urandom}, 1'($urandom));
          2: add_item(mmps_pkg::ModeLoad, 4'($urandom), 5'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom), {16'($urandom), $urandom},
                      1'($urandom));
          3, 4, 5, 6: begin
            // replay a valid signature so that matches come up
            s = $urandom_range(0, NumSlots - 1);
            if (sig_valid[s]) begin
              for (int i = 0; i < sig_len[s]; i++)
                scan_byte(sig_wild[s][i] ? 8'($urandom) : sig_byte[s][i],
                          ($urandom_range(0, 40) == 0));
            end else begin
              scan_byte(8'($urandom), 1'b0);
            end
          end
          default: scan_byte(($urandom_range(0, 1) != 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 3)),
                             ($urandom_range(0, 15) == 0));
        endcase
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("covered %0d items, %0d results checked, %0d of them matches",
             n_items, n_results, n_matches);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // driver: bursts with random gaps
  int unsigned burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    scan_item_t it;
    if (rst_ni) begin
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          it = pending_q.pop_front();
          mode            <= it.mode;
          pattern_index   <= it.idx;
          byte_pos        <= it.pos;
          data_byte       <= it.data;
          wildcard_req    <= it.wild;
          last_of_pattern <= it.lastp;
          address         <= it.addr;
          region_start    <= it.rstart;
          in_valid        <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // monitor: checks each result transfer, stalls on its own pattern
  int unsigned hold_left = 0, stall_left = 0, rx_cycles = 0;
  always @(posedge clk_i) begin
    scan_result_t e;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (kind == mmps_pkg::KindMatch) n_matches++;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d slot %0d", kind, slot));
        end else begin
          e = expected_q.pop_front();
          if (kind !== e.kind || slot !== e.slot || match_address !== e.addr ||
              found !== e.found || all_found !== e.all_found || last !== e.last)
            report($sformatf({"got k%0d s%0d a%h f%0d af%0d l%0d ",
                              "exp k%0d s%0d a%h f%0d af%0d l%0d"},
                             kind, slot, match_address, found, all_found, last,
                             e.kind, e.slot, e.addr, e.found, e.all_found, e.last));
        end
      end
      rx_cycles++;
      if (rx_cycles == HoldStart) hold_left = HoldCycles;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ((rx_cycles % 1500) > 400 && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 8);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
